### rtl/assert_macros.svh
// Assertion macros used by the crank decoder controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CMTD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crank decoder check failed");

// Next-cycle implication, checked outside reset.
`define CMTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crank decoder check failed");

`endif

### rtl/cmtd_pkg.sv
// Shared constants and controller/datapath interface types for the crank decoder.
package cmtd_pkg;

  localparam int TIME_W   = 32;
  localparam int INDEX_W  = 8;
  localparam int ANGLE_W  = 20;
  localparam int RATE_W   = 32;
  localparam int STEP_W   = 16;
  localparam int CAL_W    = 16;
  localparam int RATIO_W  = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int OUT_FIELDS_W = INDEX_W + ANGLE_W + TIME_W + RATE_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W  = 2;

  localparam int DIV_STEPS = RATE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [STEP_W-1:0]  TOOTH_STEP_RST = 16'd2769;
  localparam logic [CAL_W-1:0]   CAL_ANGLE_RST  = 16'd0;
  localparam logic [RATIO_W-1:0] GAP_RATIO_RST  = 6'd14;
  localparam logic [3:0]         PERIOD_SCALE   = 4'd10;

  localparam logic [INDEX_W-1:0] INDEX_MAX = '1;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOOTH_STEP = 2'd0,
    REG_CAL_ANGLE  = 2'd1,
    REG_GAP_RATIO  = 2'd2
  } cfg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // take the edge word, form the period
    logic eval;      // gap test, counter update, divider setup
    logic div_step;  // one restoring-division step
    logic out_load;  // move the finished result into the output register
  } cmtd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;  // the current division step is the last one
  } cmtd_status_t;

endpackage

### rtl/cmtd_ctrl.sv
// Sequencing state machine for the crank decoder.
`include "assert_macros.svh"

module cmtd_ctrl
  import cmtd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         out_tready,
  output logic         out_tvalid,
  input  cmtd_status_t status,
  output cmtd_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == ST_IDLE) && in_tvalid;
    cmd.eval     = (state_r == ST_EVAL);
    cmd.div_step = (state_r == ST_DIV);
    cmd.out_load = (state_r == ST_DONE) && out_free;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `CMTD_ASSERT_NEXT(a_load_to_eval, clk, rst_n, cmd.load, state_r == ST_EVAL)
  `CMTD_ASSERT_NEXT(a_eval_to_div, clk, rst_n, state_r == ST_EVAL, state_r == ST_DIV)
  `CMTD_ASSERT_NEXT(a_div_holds, clk, rst_n,
    (state_r == ST_DIV) && !status.div_done, state_r == ST_DIV)
  `CMTD_ASSERT_NEXT(a_result_shown, clk, rst_n, cmd.out_load,
    out_valid_r && (state_r == ST_IDLE))

endmodule

### rtl/cmtd_dp.sv
// Datapath of the crank decoder: config, tooth state, divider and output register.
module cmtd_dp
  import cmtd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [TIME_W-1:0]       edge_time,
  input  cmtd_cmd_t               cmd,
  output cmtd_status_t            status,
  output logic [OUT_TDATA_W-1:0]  out_tdata,
  output logic [OUT_TUSER_W-1:0]  out_tuser
);

  localparam int PROD_W = TIME_W + RATIO_W;

  logic [STEP_W-1:0]  step_r;
  logic [CAL_W-1:0]   cal_r;
  logic [RATIO_W-1:0] ratio_r;

  logic [TIME_W-1:0]  last_edge_r;
  logic [TIME_W-1:0]  last_period_r;
  logic [INDEX_W-1:0] tooth_r;
  logic [ANGLE_W-1:0] angle_r;

  logic [TIME_W-1:0]    per_r;
  logic                 gap_r;
  logic                 zero_r;
  logic [TIME_W-1:0]    rem_r;
  logic [RATE_W-1:0]    quo_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  logic [OUT_TDATA_W-1:0] tdata_r;
  logic [OUT_TUSER_W-1:0] tuser_r;

  logic [PROD_W-1:0]  lhs, rhs;
  logic               gap;
  logic [ANGLE_W:0]   angle_sum;
  logic [TIME_W:0]    rem_shift;
  logic [TIME_W:0]    rem_diff;
  logic               fits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= TOOTH_STEP_RST;
      cal_r   <= CAL_ANGLE_RST;
      ratio_r <= GAP_RATIO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOOTH_STEP: step_r  <= cfg_data[STEP_W-1:0];
        REG_CAL_ANGLE:  cal_r   <= cfg_data[CAL_W-1:0];
        REG_GAP_RATIO:  ratio_r <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // Gap test: period * 10 against previous period * ratio, both exact.
  assign lhs = PROD_W'(per_r) * PROD_W'(PERIOD_SCALE);
  assign rhs = PROD_W'(last_period_r) * PROD_W'(ratio_r);
  assign gap = lhs > rhs;

  assign angle_sum = {1'b0, angle_r} + (ANGLE_W+1)'(step_r);

  // Restoring division, one quotient bit per step, dividend shifts out of quo_r.
  assign rem_shift = {rem_r, quo_r[RATE_W-1]};
  assign rem_diff  = rem_shift - {1'b0, per_r};
  assign fits      = !rem_diff[TIME_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r   <= '0;
      last_period_r <= '0;
      tooth_r       <= '0;
      angle_r       <= '0;
      div_cnt_r     <= '0;
    end else begin
      if (cmd.load) begin
        last_edge_r <= edge_time;
      end
      if (cmd.eval) begin
        last_period_r <= per_r;
        div_cnt_r     <= '0;
        if (gap) begin
          tooth_r <= '0;
          angle_r <= ANGLE_W'(cal_r);
        end else begin
          if (tooth_r != INDEX_MAX) begin
            tooth_r <= tooth_r + 1'b1;
          end
          angle_r <= angle_sum[ANGLE_W] ? ANGLE_MAX : angle_sum[ANGLE_W-1:0];
        end
      end
      if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      per_r <= edge_time - last_edge_r;
    end
    if (cmd.eval) begin
      gap_r  <= gap;
      zero_r <= (per_r == '0);
      rem_r  <= '0;
      quo_r  <= {step_r, {(RATE_W-STEP_W){1'b0}}};
    end
    if (cmd.div_step) begin
      if (fits) begin
        rem_r <= rem_diff[TIME_W-1:0];
      end else begin
        rem_r <= rem_shift[TIME_W-1:0];
      end
      quo_r <= {quo_r[RATE_W-2:0], fits};
    end
    if (cmd.out_load) begin
      tdata_r <= {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                  (zero_r ? {RATE_W{1'b1}} : quo_r), per_r, angle_r, tooth_r};
      tuser_r <= {zero_r, gap_r};
    end
  end

  assign status.div_done = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign out_tdata = tdata_r;
  assign out_tuser = tuser_r;

endmodule

### rtl/crank_missing_tooth_decoder_unit.sv
// Top level of the missing-tooth crank position decoder.
//
// Each input word on the in_ channel is one rising edge of the crank
// tachometer, carrying a free-running microsecond timestamp. For every edge
// the block returns exactly one result word on the out_ channel: the tooth
// index since the last gap, the crank angle, the period since the previous
// edge, the angular rate (tooth step * 65536 / period) and two flags.
// The cfg_ channel writes the tooth step, calibration angle and gap ratio;
// it is always ready and should be used only while no edge is in flight.
// An edge's result is shown once these steps are through: the period
// is formed at the accepting clock edge, the gap test and counter update
// run next, the radix-2 restoring divider then sets the rate, and a last
// step loads the output register.
// One edge is processed at a time, so a new edge is taken only once the
// last result is loaded. The result sits in an output register; while it
// waits to be taken the next edge is accepted and computed, and only the
// final load stalls until out_tready frees the register.
// Reset (rst_n low at a clock edge) clears the timing history, tooth count
// and angle, restores the register defaults and drops out_tvalid.
module crank_missing_tooth_decoder_unit
  import cmtd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // Edge input channel.
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [TIME_W-1:0]       in_tdata,   // [31:0] edge_time
  // Result channel.
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // [7:0] tooth_index, [27:8] crank_angle, [59:28] period,
  // [91:60] angular_rate, [95:92] zero
  output logic [OUT_TDATA_W-1:0]  out_tdata,
  output logic [OUT_TUSER_W-1:0]  out_tuser,  // [0] gap_seen, [1] zero_period
  // Register write channel.
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  cmtd_cmd_t    cmd;
  cmtd_status_t status;

  // Registers can always be written; a write to an unused index is dropped.
  assign cfg_ready = 1'b1;

  cmtd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .status     (status),
    .cmd        (cmd)
  );

  cmtd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .edge_time (in_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

### dv/crank_decoder_checker.sv
// Watches the crank decoder's channels, predicts each result word and compares it.
module crank_decoder_checker
  import cmtd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [TIME_W-1:0]      in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [OUT_TUSER_W-1:0] out_tuser,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     faults,
  output int                     results_seen,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [INDEX_W-1:0] tooth_index;
    logic [ANGLE_W-1:0] crank_angle;
    logic [TIME_W-1:0]  period;
    logic [RATE_W-1:0]  angular_rate;
    logic               gap_seen;
    logic               zero_period;
  } tooth_result_t;

  // Register copies and decoder history, kept in step with the block.
  logic [STEP_W-1:0]  step_cfg;
  logic [CAL_W-1:0]   cal_cfg;
  logic [RATIO_W-1:0] ratio_cfg;
  logic [TIME_W-1:0]  prev_stamp;
  logic [TIME_W-1:0]  prev_span;
  logic [INDEX_W-1:0] teeth;
  logic [ANGLE_W-1:0] angle;

  tooth_result_t tooth_results_due[$];

  // Advances the decoder history by one edge and returns what the block must report.
  function automatic tooth_result_t decode_edge(input logic [TIME_W-1:0] stamp);
    tooth_result_t r;
    logic [TIME_W-1:0]  span;
    logic [63:0]        scaled, limit, dividend, divisor, quot;
    logic [ANGLE_W:0]   sum;
    span = stamp - prev_stamp;
    scaled = 64'(span);
    scaled = scaled * 64'd10;
    limit = 64'(prev_span);
    limit = limit * 64'(ratio_cfg);
    r.gap_seen = scaled > limit;
    r.zero_period = (span == '0);
    if (r.gap_seen) begin
      teeth = '0;
      angle = ANGLE_W'(cal_cfg);
    end else begin
      sum = {1'b0, angle} + (ANGLE_W+1)'(step_cfg);
      if (teeth != INDEX_MAX) teeth = teeth + 1'b1;
      angle = (sum > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : sum[ANGLE_W-1:0];
    end
    if (r.zero_period) begin
      r.angular_rate = '1;
    end else begin
      dividend = 64'({step_cfg, 16'd0});
      divisor = 64'(span);
      quot = dividend / divisor;
      r.angular_rate = quot[RATE_W-1:0];
    end
    prev_stamp = stamp;
    prev_span = span;
    r.tooth_index = teeth;
    r.crank_angle = angle;
    r.period = span;
    return r;
  endfunction

  function automatic string show(input tooth_result_t r);
    return $sformatf("index %0d angle %0d period %0d rate %0d gap %0b zero %0b",
                     r.tooth_index, r.crank_angle, r.period, r.angular_rate,
                     r.gap_seen, r.zero_period);
  endfunction

  always @(posedge clk) begin
    tooth_result_t got, want;
    logic [OUT_TDATA_W-OUT_FIELDS_W-1:0] pad;
    if (!rst_n) begin
      step_cfg = TOOTH_STEP_RST;
      cal_cfg = CAL_ANGLE_RST;
      ratio_cfg = GAP_RATIO_RST;
      prev_stamp = '0;
      prev_span = '0;
      teeth = '0;
      angle = '0;
      tooth_results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TOOTH_STEP: step_cfg = cfg_data;
          REG_CAL_ANGLE:  cal_cfg = cfg_data;
          REG_GAP_RATIO:  ratio_cfg = cfg_data[RATIO_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        got.tooth_index  = out_tdata[0 +: INDEX_W];
        got.crank_angle  = out_tdata[INDEX_W +: ANGLE_W];
        got.period       = out_tdata[INDEX_W+ANGLE_W +: TIME_W];
        got.angular_rate = out_tdata[INDEX_W+ANGLE_W+TIME_W +: RATE_W];
        got.gap_seen     = out_tuser[0];
        got.zero_period  = out_tuser[1];
        pad = out_tdata[OUT_TDATA_W-1:OUT_FIELDS_W];
        if (tooth_results_due.size() == 0) begin
          faults++;
          if (faults <= 10) $display("%0t: result word with none expected: %s", $time, show(got));
        end else begin
          want = tooth_results_due.pop_front();
          if (got !== want || pad !== '0) begin
            faults++;
            if (faults <= 10)
              $display("%0t: result mismatch\n  expected %s\n  actual   %s pad %h",
                       $time, show(want), show(got), pad);
          end
        end
      end
      if (in_tvalid && in_tready) tooth_results_due.push_back(decode_edge(in_tdata));
    end
    outstanding = tooth_results_due.size();
  end

endmodule

### dv/tb_crank_missing_tooth_decoder_unit.sv
// Testbench top for the crank decoder: edge stimulus, register writes, back-pressure, verdict.
module tb_crank_missing_tooth_decoder_unit;
  import cmtd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [TIME_W-1:0]      in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int faults;
  int results_seen;
  int outstanding;

  // Stimulus-side view of the wheel: the time stamp of the last edge sent, the spacing
  // that led to it and the gap ratio now in force. These only shape the stimulus; the
  // checker keeps its own history for prediction.
  logic [TIME_W-1:0]  edge_clock = '0;
  logic [TIME_W-1:0]  last_spacing = '0;
  logic [RATIO_W-1:0] ratio_now = GAP_RATIO_RST;
  int                 edges_sent = 0;

  // When steady is set neither side idles. hold_req asks the receiver for one long
  // hold-off; the receiver clears it once it has taken the request.
  bit steady = 1'b0;
  bit hold_req = 1'b0;

  always #5ns clk = ~clk;

  crank_missing_tooth_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  crank_decoder_checker decode_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .faults       (faults),
    .results_seen (results_seen),
    .outstanding  (outstanding)
  );

  // Offers one edge word and returns at the clock edge that accepts it. Valid is left
  // high after the handshake: the next call either keeps it up for a back-to-back word
  // or drops it for an idle gap, so valid never gets two updates in one time step.
  task automatic emit_edge(input logic [TIME_W-1:0] stamp);
    while (!steady && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= stamp;
    do @(posedge clk); while (!in_tready);
    last_spacing = stamp - edge_clock;
    edge_clock = stamp;
    edges_sent++;
  endtask

  // Sends the next edge a given number of microseconds after the previous one; the time
  // stamp wraps freely.
  task automatic advance(input logic [TIME_W-1:0] span);
    emit_edge(edge_clock + span);
  endtask

  // Stops offering edges and waits until every edge sent so far has its result word.
  task automatic drain();
    in_tvalid <= 1'b0;
    wait (results_seen >= edges_sent);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_GAP_RATIO) ratio_now = value[RATIO_W-1:0];
  endtask

  // Registers are only rewritten with the decoder idle, i.e. with no edge in flight.
  task automatic configure(input logic [CFG_DATA_W-1:0] step, cal, ratio_word);
    drain();
    write_reg(REG_TOOTH_STEP, step);
    write_reg(REG_CAL_ANGLE, cal);
    write_reg(REG_GAP_RATIO, ratio_word);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic. Most of it looks like a real trigger wheel: a run of evenly spaced
  // teeth with a little jitter, closed by the long missing-tooth gap. The rest sits on
  // the gap threshold exactly (and one microsecond past it), repeats a time stamp or
  // steps by one or two microseconds, or jumps to an arbitrary time stamp.
  task automatic spin_wheel(input int count);
    int                 stop_at, teeth, pick, k;
    logic [TIME_W-1:0]  base;
    logic [63:0]        threshold;
    stop_at = edges_sent + count;
    while (edges_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        teeth = $urandom_range(3, 40);
        base = $urandom_range(16, 32'd1 << $urandom_range(5, 20));
        for (k = 1; k < teeth && edges_sent < stop_at; k++)
          advance(base - (base >> 5) + $urandom_range(0, base >> 4));
        if (edges_sent < stop_at) advance(base * $urandom_range(12, 45) / 10);
      end else if (pick < 80) begin
        // A spacing that is a multiple of ten makes the threshold an exact integer.
        advance(10 * $urandom_range(1, 50000));
        threshold = 64'(last_spacing);
        threshold = threshold * 64'(ratio_now) / 64'd10;
        advance(threshold[TIME_W-1:0] + $urandom_range(0, 1));
      end else if (pick < 90) begin
        advance($urandom_range(0, 2));
      end else begin
        emit_edge($urandom());
      end
    end
  endtask

  // Receiver: takes result words with random idle cycles, except while steady is set,
  // and honors one long hold-off counted here so the decoder backs up and stalls its
  // input while the sender keeps offering edges.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = 400;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 18);
      end
    end
  end

  initial begin : edge_source
    int n;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_TOOTH_STEP;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed edges under the reset register values (step 2769, angle 0, ratio 1.4).
    // The first edge lands at time zero, so its period is zero: the rate saturates and,
    // with no history, it is not a gap.
    advance(0);
    advance(1000);          // any nonzero period after a zero one is a gap
    advance(1000);
    advance(1400);          // exactly 1.4 times the last period: still a tooth
    advance(1960);          // exactly on the threshold again
    advance(2745);          // one microsecond past the threshold: a gap
    advance(1);             // shortest period, largest rate
    advance(0);             // repeated time stamp
    advance(0);
    advance(5);
    emit_edge(32'hFFFF_FFF0);
    advance(32);            // time stamp wraps through zero
    advance(32'hFFFF_FFFF); // time steps back by one: the longest period
    emit_edge(32'hFFFF_FFFF);
    emit_edge(32'h0000_0000);
    emit_edge(32'hAAAA_AAAA);
    emit_edge(32'h5555_5555);

    // Largest legal step, calibration and ratio. A long run without a gap drives the
    // angle into saturation early and the tooth index to its ceiling later.
    configure(16'd36000, 16'd36000, 16'd40);
    for (n = 0; n < 262; n++) advance(500 + $urandom_range(0, 20));
    spin_wheel(40);

    // Smallest legal values, with the long receiver hold-off in the middle.
    configure(16'd1, 16'd0, 16'd10);
    spin_wheel(20);
    hold_req = 1'b1;
    spin_wheel(60);

    // A typical wheel with no idling on either side, and one full pause of the sender.
    configure(16'd1000, 16'd1234, 16'd15);
    steady = 1'b1;
    spin_wheel(40);
    drain();
    spin_wheel(40);
    steady = 1'b0;

    // Values outside the usual range are taken at their width: a zero step gives a zero
    // rate, a zero ratio makes every nonzero period a gap, all ones gives ratio 6.3.
    configure(16'd0, 16'hFFFF, 16'd0);
    spin_wheel(50);
    configure(16'hFFFF, 16'($urandom_range(0, 36000)), 16'hFFFF);
    spin_wheel(60);

    repeat (3) begin
      configure(16'($urandom_range(1, 36000)), 16'($urandom_range(0, 36000)),
                16'($urandom_range(10, 40)));
      spin_wheel(40);
    end

    // Let the last edge finish and give a stray extra word time to show up.
    drain();
    repeat (40) @(posedge clk);
    if (faults == 0 && outstanding == 0) begin
      $display("tb_crank_missing_tooth_decoder_unit: done, clean");
    end else begin
      $display("tb_crank_missing_tooth_decoder_unit: done, errors");
    end
    $finish;
  end

  // A correct run needs well under a tenth of this.
  initial begin : watchdog
    #5ms;
    $display("tb_crank_missing_tooth_decoder_unit: done, errors");
    $finish;
  end

endmodule
